// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the locator RTL files.
// Each macro wraps one clocked concurrent assertion with a synchronous-reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlvcfl_pkg.sv =====
// Shared types and constants for the TLV content field locator.
// Used by the parser, the result register and the top level; no dependencies.
package tlvcfl_pkg;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_EXT  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // First length byte codes.
  localparam logic [7:0] LEN_DIRECT_MAX = 8'hFC;
  localparam logic [7:0] LEN_EXT2_CODE  = 8'hFD;
  localparam logic [7:0] LEN_EXT4_CODE  = 8'hFE;

  // Number of extended length bytes that follow each code.
  localparam logic [3:0] EXT2_BYTES = 4'd2;
  localparam logic [3:0] EXT4_BYTES = 4'd4;
  localparam logic [3:0] EXT8_BYTES = 4'd8;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // Configuration register indexes and reset values.
  localparam logic CFG_OUTER_TYPE  = 1'b0;
  localparam logic CFG_TARGET_TYPE = 1'b1;
  localparam logic [7:0] OUTER_TYPE_RESET  = 8'd6;
  localparam logic [7:0] TARGET_TYPE_RESET = 8'd21;

  typedef struct packed {
    logic [7:0] outer_type;
    logic [7:0] target_type;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  tlv_type;
    logic [63:0] value_length;
    logic [15:0] value_offset;
  } result_t;

endpackage

// ===== hw/rtl/tlvcfl_parser.sv =====
// Byte-wide TLV walker: holds the parse state and forms at most one result per word.
// Depends on tlvcfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlvcfl_parser
  import tlvcfl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic [7:0] pkt_byte,
  input  logic    last_byte,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  left, left_next;
  logic [63:0] accum, accum_next;
  logic [15:0] pos, pos_next;
  logic [63:0] skip, skip_next;
  logic [7:0]  cur_type, cur_type_next;
  logic        reported, reported_next;

  logic [15:0] pos_inc;
  logic [3:0]  left_dec;
  logic [63:0] skip_dec;
  logic        len_done;
  logic        hit;
  logic [16:0] off_sum;
  logic [15:0] end_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      left     <= '0;
      accum    <= '0;
      pos      <= '0;
      skip     <= '0;
      cur_type <= '0;
      reported <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      left     <= left_next;
      accum    <= accum_next;
      pos      <= pos_next;
      skip     <= skip_next;
      cur_type <= cur_type_next;
      reported <= reported_next;
    end
  end

  assign pos_inc  = (pos != POS_MAX) ? pos + 16'd1 : pos;
  assign left_dec = (left != 4'd0) ? left - 4'd1 : 4'd0;
  assign skip_dec = (skip != 64'd0) ? skip - 64'd1 : 64'd0;

  always_comb begin
    phase_next    = phase;
    left_next     = left;
    accum_next    = accum;
    pos_next      = pos;
    skip_next     = skip;
    cur_type_next = cur_type;
    reported_next = reported;
    len_done      = 1'b0;
    hit           = 1'b0;

    if (!reported) begin
      case (phase)
        PH_LEN: begin
          pos_next = pos_inc;
          if (pkt_byte <= LEN_DIRECT_MAX) begin
            accum_next = {56'd0, pkt_byte};
            len_done   = 1'b1;
          end else begin
            accum_next = '0;
            if (pkt_byte == LEN_EXT2_CODE) begin
              left_next = EXT2_BYTES;
            end else if (pkt_byte == LEN_EXT4_CODE) begin
              left_next = EXT4_BYTES;
            end else begin
              left_next = EXT8_BYTES;
            end
            phase_next = PH_EXT;
          end
        end
        PH_EXT: begin
          pos_next   = pos_inc;
          accum_next = {accum[55:0], pkt_byte};
          left_next  = left_dec;
          len_done   = (left_dec == 4'd0);
        end
        PH_SKIP: begin
          pos_next  = pos_inc;
          skip_next = skip_dec;
          if (skip_dec == 64'd0) begin
            phase_next = PH_TYPE;
          end
        end
        default: begin
          pos_next      = pos_inc;
          cur_type_next = pkt_byte;
          accum_next    = '0;
          phase_next    = PH_LEN;
        end
      endcase

      // Length field complete: report, enter, or skip the value.
      if (len_done) begin
        if (cur_type == cfg.target_type) begin
          hit = 1'b1;
        end else if (cur_type == cfg.outer_type || accum_next == 64'd0) begin
          phase_next = PH_TYPE;
        end else begin
          skip_next  = accum_next;
          phase_next = PH_SKIP;
        end
      end

      if (hit && !last_byte) begin
        reported_next = 1'b1;
      end
    end

    // A packet that ends inside a skipped value reports where the skip would end.
    off_sum = {1'b0, pos_next} + {1'b0, skip_next[15:0]};
    end_off = pos_next;
    if (phase_next == PH_SKIP) begin
      if (skip_next[63:16] != 48'd0 || off_sum >= {1'b0, POS_MAX}) begin
        end_off = POS_MAX;
      end else begin
        end_off = off_sum[15:0];
      end
    end

    // Every end of packet re-arms the parser.
    if (last_byte) begin
      phase_next    = PH_TYPE;
      left_next     = '0;
      accum_next    = '0;
      pos_next      = '0;
      skip_next     = '0;
      cur_type_next = '0;
      reported_next = 1'b0;
    end
  end

  assign res_valid = accept && !reported && (hit || last_byte);

  always_comb begin
    res.found        = hit;
    res.value_length = (phase == PH_TYPE) ? 64'd0 :
                       (phase == PH_LEN && pkt_byte <= LEN_DIRECT_MAX) ? {56'd0, pkt_byte} :
                       (phase == PH_LEN) ? 64'd0 :
                       (phase == PH_EXT) ? {accum[55:0], pkt_byte} : accum;
    res.tlv_type     = (phase == PH_TYPE) ? pkt_byte : cur_type;
    res.value_offset = hit ? pos_inc : end_off;
  end

  `ASSERT_NEXT(a_hold_hit, clk, rst, res_valid && hit && !last_byte, reported, "hit not held")
  `ASSERT_NEXT(a_rearm, clk, rst, accept && last_byte, pos == 16'd0 && !reported, "no re-arm")
  `ASSERT_IMPLIES(a_quiet_done, clk, rst, reported, !res_valid, "result after report")
  `ASSERT_IMPLIES(a_skip_nonzero, clk, rst, phase == PH_SKIP, skip != 64'd0, "empty skip")

endmodule

// ===== hw/rtl/tlvcfl_out_reg.sv =====
// Result register for the locator: holds one result word until the sink takes it.
// Depends on tlvcfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlvcfl_out_reg
  import tlvcfl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic valid;
  result_t res_q;

  // A new word may enter whenever the held word is empty or leaves this cycle.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_q <= in_res;
    end
  end

  assign out_valid = valid;
  assign out_res   = res_q;

  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, in_valid, in_ready, "result offered while full")

endmodule

// ===== hw/rtl/tlv_content_field_locator.sv =====
// TLV content field locator, top level: a stream of packet bytes comes in, one byte per
// word with tlast on the final byte. The block walks the type-length-value elements
// (one-byte type, then a length byte up to 0xFC or 0xFD/0xFE/0xFF followed by 2, 4 or 8
// big-endian length bytes), enters the element whose type is outer_type_code and skips
// the value of any other. At the first element of type target_type_code it sends one
// result word with found set, the element's type, its length and the offset of its first
// value byte; the rest of that packet is then consumed silently. A packet that ends first
// yields one result with found clear and the last parse state. Offsets saturate at 65535.
// The block takes one byte per cycle while s_tready is high: each byte updates the parse
// state when it is accepted, and the result register in front of the master side lets
// the next byte enter in the cycle a waiting result leaves. s_tready drops only while that
// register is full and m_tready is low. Depends on tlvcfl_pkg, tlvcfl_parser and tlvcfl_out_reg.

module tlv_content_field_locator
  import tlvcfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port: index 0 is outer_type_code, index 1 is target_type_code.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Slave side.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pkt_byte
  input  logic        s_tlast,   // last_byte
  // Master side.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [7:0] tlv_type, [71:8] value_length, [87:72] value_offset
  output logic        m_tuser    // found
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Config registers: the user ensures they are only written while no packet is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_type  <= OUTER_TYPE_RESET;
      cfg.target_type <= TARGET_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTER_TYPE:  cfg.outer_type  <= cfg_data;
        CFG_TARGET_TYPE: cfg.target_type <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A word is accepted whenever the result register can absorb what it might produce.
  assign accept = s_tvalid && s_tready;

  tlvcfl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pkt_byte  (s_tdata),
    .last_byte (s_tlast),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  tlvcfl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the result word: type in the low byte, then length, then offset.
  assign m_tdata = {out_res.value_offset, out_res.value_length, out_res.tlv_type};
  assign m_tuser = out_res.found;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for tlv_content_field_locator: streams packets byte by byte and
// checks every report against a cycle-free predictor of the TLV walk.
// Depends on tlvcfl_pkg and the tlv_content_field_locator RTL; reads no files.

module tb;
  import tlvcfl_pkg::*;

  localparam logic [7:0] LEN_EXT8_CODE = 8'hFF;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         PHASE_BYTES   = 320;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One directed word, with the report typed in where it is obvious.
  typedef struct {
    logic [7:0]  b;
    logic        last;
    bit          typed;
    logic        e_found;
    logic [7:0]  e_type;
    logic [63:0] e_len;
    logic [15:0] e_off;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_OUTER_TYPE;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;   // [7:0] tlv_type, [71:8] value_length, [87:72] value_offset
  logic        m_tuser;   // found

  tlv_content_field_locator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the configuration and of the walk state.
  logic [7:0]  outer_cfg = OUTER_TYPE_RESET;
  logic [7:0]  target_cfg = TARGET_TYPE_RESET;
  phase_t      walk_phase = PH_TYPE;
  logic [3:0]  ext_left = '0;
  logic [63:0] len_acc = '0;
  logic [15:0] pos = '0;
  logic [63:0] skip_left = '0;
  logic [7:0]  cur_type = '0;
  bit          pkt_done = 1'b0;

  result_t     expected_reports[$];
  result_t     want;
  logic [7:0]  pkt_q[$];
  logic [7:0]  body_q[$];

  idle_mode_t  mode = IDLE_NONE;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          n_bytes = 0;
  int          n_packets = 0;
  int          n_reports = 0;
  int          n_found = 0;

  task automatic rearm_walk();
    walk_phase = PH_TYPE;
    ext_left = '0;
    len_acc = '0;
    pos = '0;
    skip_left = '0;
    cur_type = '0;
    pkt_done = 1'b0;
  endtask

  // The length field is complete: report the target, enter the outer element, or skip.
  // A target type that equals the outer type is reported, not entered.
  function automatic bit close_length();
    if (cur_type == target_cfg) return 1'b1;
    if (cur_type == outer_cfg || len_acc == 64'd0) begin
      walk_phase = PH_TYPE;
    end else begin
      skip_left = len_acc;
      walk_phase = PH_SKIP;
    end
    return 1'b0;
  endfunction

  // Advances the walk by one accepted packet byte and says whether it yields a report.
  task automatic locate_step(input logic [7:0] b, input logic last, output bit got,
                             output result_t res);
    bit hit;
    logic [15:0] off;
    hit = 1'b0;
    got = 1'b0;
    res = '0;
    if (pkt_done) begin
      // Rest of a packet whose target was already reported: silent until tlast.
      if (last) rearm_walk();
      return;
    end
    if (pos != POS_MAX) pos = pos + 16'd1;
    case (walk_phase)
      PH_LEN: begin
        if (b <= LEN_DIRECT_MAX) begin
          len_acc = {56'd0, b};
          hit = close_length();
        end else begin
          len_acc = '0;
          ext_left = (b == LEN_EXT2_CODE) ? EXT2_BYTES :
                     (b == LEN_EXT4_CODE) ? EXT4_BYTES : EXT8_BYTES;
          walk_phase = PH_EXT;
        end
      end
      PH_EXT: begin
        len_acc = {len_acc[55:0], b};
        if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) hit = close_length();
      end
      PH_SKIP: begin
        if (skip_left != 64'd0) skip_left = skip_left - 64'd1;
        if (skip_left == 64'd0) walk_phase = PH_TYPE;
      end
      default: begin
        cur_type = b;
        len_acc = '0;
        walk_phase = PH_LEN;
      end
    endcase
    if (hit || last) begin
      off = pos;
      // A packet cut inside a skipped value reports where the skip would have ended.
      if (!hit && walk_phase == PH_SKIP)
        off = (skip_left >= 64'(POS_MAX - pos)) ? POS_MAX : pos + skip_left[15:0];
      got = 1'b1;
      res.found = hit;
      res.tlv_type = cur_type;
      res.value_length = len_acc;
      res.value_offset = off;
      if (last) rearm_walk();
      else pkt_done = 1'b1;
    end
  endtask

  task automatic set_mode(input idle_mode_t m);
    mode = m;
    send_idle_pct = (m == IDLE_SEND) ? 73 : (m == IDLE_BOTH) ? 37 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 73 : (m == IDLE_BOTH) ? 37 : 0;
  endtask

  // Called at a falling edge; returns at a falling edge with s_tvalid still high, so the
  // next word can follow without a bubble. Whoever stops sending lowers s_tvalid.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed,
                           input result_t fixed_res);
    bit got;
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 8'($urandom_range(0, 255));
      s_tlast = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_bytes++;
    if (last) n_packets++;
    locate_step(b, last, got, res);
    if (fixed) expected_reports.push_back(fixed_res);
    else if (got) expected_reports.push_back(res);
    @(negedge clk);
  endtask

  // Stop sending, let every expected report arrive, then let the parser settle on words
  // that produce no report.
  task automatic drain_reports();
    s_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_OUTER_TYPE) outer_cfg = val;
    else target_cfg = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Encodes a length in one of the legal forms, picked at random where several fit.
  task automatic put_len(ref logic [7:0] q[$], input logic [63:0] n);
    int form;
    int nb;
    if (n <= 64'hFC) form = $urandom_range(0, 3);
    else if (n <= 64'hFFFF) form = $urandom_range(1, 3);
    else if (n <= 64'hFFFF_FFFF) form = $urandom_range(2, 3);
    else form = 3;
    nb = 0;
    case (form)
      0: q.push_back(n[7:0]);
      1: begin
        q.push_back(LEN_EXT2_CODE);
        nb = int'(EXT2_BYTES);
      end
      2: begin
        q.push_back(LEN_EXT4_CODE);
        nb = int'(EXT4_BYTES);
      end
      default: begin
        q.push_back(LEN_EXT8_CODE);
        nb = int'(EXT8_BYTES);
      end
    endcase
    for (int i = nb - 1; i >= 0; i--) q.push_back(n[8*i +: 8]);
  endtask

  // Builds one packet: mostly an outer element holding a few children, some of them of
  // the target type; sometimes cut short, sometimes plain noise.
  task automatic send_random_packet();
    int kind;
    int r;
    int nchild;
    int nval;
    logic [7:0]  t;
    logic [63:0] n;
    result_t none;
    none = '0;
    pkt_q.delete();
    body_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      nchild = $urandom_range(1, 4);
      for (int c = 0; c < nchild; c++) begin
        r = $urandom_range(0, 99);
        if (r < 25) t = target_cfg;
        else if (r < 35) t = outer_cfg;
        else t = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 15) n = 64'd0;
        else if (r < 90) n = 64'($urandom_range(1, 8));
        else n = {32'($urandom()), 32'($urandom())};
        body_q.push_back(t);
        put_len(body_q, n);
        nval = (n > 64'd12) ? $urandom_range(0, 12) : int'(n);
        for (int v = 0; v < nval; v++) body_q.push_back(8'($urandom_range(0, 255)));
        // A huge length cannot be filled; the packet ends inside it.
        if (n > 64'd12) break;
      end
      if ($urandom_range(0, 99) < 80) begin
        pkt_q.push_back(outer_cfg);
        if ($urandom_range(0, 99) < 90) put_len(pkt_q, 64'(body_q.size()));
        else put_len(pkt_q, 64'($urandom_range(0, 300)));
      end
      foreach (body_q[i]) pkt_q.push_back(body_q[i]);
      if ($urandom_range(0, 99) < 20 && pkt_q.size() > 1)
        pkt_q = pkt_q[0 : $urandom_range(0, pkt_q.size() - 2)];
    end else begin
      nval = $urandom_range(1, 20);
      for (int v = 0; v < nval; v++) pkt_q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1, 1'b0, none);
  endtask

  // Directed words under the reset configuration (outer 6, target 21).
  dir_row_t dir_rows [24] = '{
    // Outer element entered, zero-length child skipped, target found mid-packet;
    // the trailing byte is ignored and its tlast re-arms the block.
    '{8'h06, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h05, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h07, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h15, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h03, 1'b0, 1'b1, 1'b1, 8'h15, 64'd3, 16'd6},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    // Packet ends right after a type byte.
    '{8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 64'd0, 16'd1},
    // Packet ends inside an eight-byte length.
    '{8'h07, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 8'h07, 64'd1, 16'd3},
    // Target with a two-byte length, found on the last byte.
    '{8'h15, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'hFD, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h15, 64'h100, 16'd4},
    // Packet ends inside a skipped value whose end lies past 65535.
    '{8'h08, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 8'h08, 64'h10000, 16'hFFFF},
    // Packet ends at an element boundary.
    '{8'h16, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 8'h16, 64'd0, 16'd2}
  };

  // Receiver: stalls at random according to the current mode.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Report checker: every accepted word is matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, actual tuser=%0b tdata=%h", $time, m_tuser,
                 m_tdata);
      end else begin
        want = expected_reports.pop_front();
        n_reports++;
        if (want.found) n_found++;
        if (m_tuser !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
        end
        if (m_tdata[7:0] !== want.tlv_type) begin
          errors++;
          $display("%0t: tlv_type expected %h actual %h", $time, want.tlv_type,
                   m_tdata[7:0]);
        end
        if (m_tdata[71:8] !== want.value_length) begin
          errors++;
          $display("%0t: value_length expected %h actual %h", $time, want.value_length,
                   m_tdata[71:8]);
        end
        if (m_tdata[87:72] !== want.value_offset) begin
          errors++;
          $display("%0t: value_offset expected %0d actual %0d", $time, want.value_offset,
                   m_tdata[87:72]);
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    result_t fixed_res;
    idle_mode_t phase_modes [4];
    logic [7:0] shared_type;
    int start;
    phase_modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_mode(IDLE_NONE);
    foreach (dir_rows[i]) begin
      fixed_res.found = dir_rows[i].e_found;
      fixed_res.tlv_type = dir_rows[i].e_type;
      fixed_res.value_length = dir_rows[i].e_len;
      fixed_res.value_offset = dir_rows[i].e_off;
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, fixed_res);
    end

    // Random phases: each writes both registers while idle, then streams packets.
    for (int p = 0; p < 5; p++) begin
      drain_reports();
      case (p)
        0: begin
          write_cfg(CFG_OUTER_TYPE, OUTER_TYPE_RESET);
          write_cfg(CFG_TARGET_TYPE, TARGET_TYPE_RESET);
        end
        1: begin
          write_cfg(CFG_OUTER_TYPE, 8'h00);
          write_cfg(CFG_TARGET_TYPE, 8'hFF);
        end
        2: begin
          write_cfg(CFG_OUTER_TYPE, 8'hFF);
          write_cfg(CFG_TARGET_TYPE, 8'h00);
        end
        3: begin
          // Target and outer share a type: the target is reported, never entered.
          shared_type = 8'($urandom_range(0, 255));
          write_cfg(CFG_OUTER_TYPE, shared_type);
          write_cfg(CFG_TARGET_TYPE, shared_type);
        end
        default: begin
          write_cfg(CFG_OUTER_TYPE, 8'($urandom_range(0, 255)));
          write_cfg(CFG_TARGET_TYPE, 8'($urandom_range(0, 255)));
        end
      endcase
      set_mode(phase_modes[p % 4]);
      start = n_bytes;
      while (n_bytes - start < PHASE_BYTES) send_random_packet();
    end

    drain_reports();
    repeat (10) @(negedge clk);
    $display("Streamed %0d packet bytes in %0d packets over five register settings.",
             n_bytes, n_packets);
    $display("Checked %0d reports, %0d with the target found; %0d mismatches.",
             n_reports, n_found, errors);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tlvcfl_pkg.sv
hw/rtl/tlvcfl_parser.sv
hw/rtl/tlvcfl_out_reg.sv
hw/rtl/tlv_content_field_locator.sv
dv/tb.sv
